### sv/assert_macros.svh
// Assertion macros shared by the RTL of the extra-field parser.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### sv/zefp_pkg.sv
// Package of the ZIP extra-field parser: record ids, phase codes, result word type.
// Depends on nothing; used by the parser core and the top level.
`default_nettype none

package zefp_pkg;

   localparam logic [15:0] KindTimes = 16'h5455;
   localparam logic [15:0] KindUnix  = 16'h7875;
   localparam logic [7:0]  IdMaxLen  = 8'd8;

   // Positions of the valid bits of the pending and committed values.
   localparam int unsigned ValidMtime = 0;
   localparam int unsigned ValidAtime = 1;
   localparam int unsigned ValidCtime = 2;
   localparam int unsigned ValidIds   = 3;

   // Code returned by slot_target when no flag matches.
   localparam logic [1:0] SlotNone = 2'd3;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'b01,
      PHASE_PAYLOAD = 2'b10
   } phase_type;

   typedef struct packed {
      logic        has_mtime;
      logic [31:0] mtime;
      logic        has_atime;
      logic [31:0] atime;
      logic        has_ctime;
      logic [31:0] ctime;
      logic        has_unix_ids;
      logic [31:0] user_id;
      logic [31:0] group_id;
   } result_type;

   // Index of the n-th set bit among the three time flags, or SlotNone.
   function automatic logic [1:0] slot_target(input logic [2:0] flags, input logic [1:0] n);
      logic [1:0] seen;
      logic [1:0] hit;
      seen = 2'd0;
      hit  = SlotNone;
      for (int b = 0; b < 3; b++) begin
         if (flags[b] && hit == SlotNone) begin
            if (seen == n) begin
               hit = 2'(b);
            end
            seen = seen + 2'd1;
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

### sv/zefp_req_if.sv
// Input channel of the extra-field parser: one raw byte per word, last byte marked.
// Depends on nothing.
`default_nettype none

interface zefp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### sv/zefp_rsp_if.sv
// Result channel of the extra-field parser: times and Unix ids of one extra field.
// Depends on nothing.
`default_nettype none

interface zefp_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_mtime;
   logic [31:0] mtime;
   logic        has_atime;
   logic [31:0] atime;
   logic        has_ctime;
   logic [31:0] ctime;
   logic        has_unix_ids;
   logic [31:0] user_id;
   logic [31:0] group_id;

   modport source (output valid, output has_mtime, output mtime, output has_atime,
                   output atime, output has_ctime, output ctime, output has_unix_ids,
                   output user_id, output group_id, input ready);
   modport sink   (input valid, input has_mtime, input mtime, input has_atime,
                   input atime, input has_ctime, input ctime, input has_unix_ids,
                   input user_id, input group_id, output ready);
endinterface

`default_nettype wire

### sv/zefp_parser.sv
// Record walker of the extra-field parser: header and payload state, pending and
// committed values. Depends on zefp_pkg.
`default_nettype none

module zefp_parser (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     data_byte,
   input  wire logic           last_byte,
   output zefp_pkg::result_type result
);
   import zefp_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] kind_ff,    kind_in;
   logic [15:0] len_ff,     len_in;
   logic [15:0] off_ff,     off_in;
   logic [2:0]  flags_ff,   flags_in;
   logic [7:0]  uid_len_ff, uid_len_in;
   logic [7:0]  gid_len_ff, gid_len_in;
   logic [31:0] asm_ff,     asm_in;
   logic [31:0] pend_times_ff [3];
   logic [31:0] pend_times_in [3];
   logic [31:0] pend_ids_ff [2];
   logic [31:0] pend_ids_in [2];
   logic [2:0]  pend_valid_ff, pend_valid_in;
   logic [31:0] com_times_ff [3];
   logic [31:0] com_times_in [3];
   logic [31:0] com_ids_ff [2];
   logic [31:0] com_ids_in [2];
   logic [3:0]  com_valid_ff, com_valid_in;

   logic [15:0] off_next;
   logic [15:0] rel;
   logic [31:0] word_new;
   logic [1:0]  target;
   logic [17:0] off_wide;
   logic [17:0] uid_wide;
   logic [17:0] gid_wide;
   logic [17:0] id_pos;
   logic        commit;

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      off_in        = off_ff;
      flags_in      = flags_ff;
      uid_len_in    = uid_len_ff;
      gid_len_in    = gid_len_ff;
      asm_in        = asm_ff;
      pend_times_in = pend_times_ff;
      pend_ids_in   = pend_ids_ff;
      pend_valid_in = pend_valid_ff;
      com_times_in  = com_times_ff;
      com_ids_in    = com_ids_ff;
      com_valid_in  = com_valid_ff;
      off_next      = off_ff + 16'd1;
      rel           = off_ff - 16'd1;
      word_new      = asm_ff | ({24'h0, data_byte} << {rel[1:0], 3'b000});
      target        = slot_target(flags_ff, rel[3:2]);
      off_wide      = {2'b00, off_ff};
      uid_wide      = {10'h000, uid_len_ff};
      gid_wide      = {10'h000, gid_len_ff};
      id_pos        = '0;
      commit        = 1'b0;

      if (step) begin
         if (phase_ff == PHASE_HEADER) begin
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            case (hdr_cnt_ff)
               2'd0: kind_in = {8'h00, data_byte};
               2'd1: kind_in = {data_byte, kind_ff[7:0]};
               2'd2: len_in  = {8'h00, data_byte};
               default: begin
                  // Header complete: start a fresh record. An empty record has no effect.
                  len_in        = {data_byte, len_ff[7:0]};
                  off_in        = '0;
                  flags_in      = '0;
                  uid_len_in    = '0;
                  gid_len_in    = '0;
                  asm_in        = '0;
                  pend_times_in = '{default: '0};
                  pend_ids_in   = '{default: '0};
                  pend_valid_in = '0;
                  if (len_in != 16'h0000) begin
                     phase_in = PHASE_PAYLOAD;
                  end
               end
            endcase
         end else begin
            if (kind_ff == KindTimes) begin
               if (off_ff == 16'h0000) begin
                  flags_in = data_byte[2:0];
               end else if (rel[15:2] < 14'd3) begin
                  asm_in = (rel[1:0] == 2'd0) ? {24'h0, data_byte} : word_new;
                  if (rel[1:0] == 2'd3 && target != SlotNone && word_new != 32'h0) begin
                     pend_times_in[target] = word_new;
                     pend_valid_in[target] = 1'b1;
                  end
               end
            end else if (kind_ff == KindUnix) begin
               if (off_wide == 18'd1) begin
                  uid_len_in = data_byte;
               end else if (off_wide >= 18'd2 && off_wide < 18'd2 + uid_wide) begin
                  id_pos = off_wide - 18'd2;
                  if (uid_len_ff != 8'h00 && uid_len_ff <= IdMaxLen && id_pos < 18'd4) begin
                     pend_ids_in[0] = pend_ids_ff[0]
                                    | ({24'h0, data_byte} << {id_pos[1:0], 3'b000});
                  end
               end else if (off_wide == 18'd2 + uid_wide) begin
                  gid_len_in = data_byte;
               end else if (off_wide >= 18'd3 + uid_wide &&
                            off_wide < 18'd3 + uid_wide + gid_wide) begin
                  id_pos = off_wide - 18'd3 - uid_wide;
                  if (gid_len_ff != 8'h00 && gid_len_ff <= IdMaxLen && id_pos < 18'd4) begin
                     pend_ids_in[1] = pend_ids_ff[1]
                                    | ({24'h0, data_byte} << {id_pos[1:0], 3'b000});
                  end
               end
            end
            off_in = off_next;
            if (off_next == len_ff) begin
               commit     = 1'b1;
               phase_in   = PHASE_HEADER;
               hdr_cnt_in = '0;
            end
         end
      end

      // A finished record overwrites what earlier records left for the values it carries.
      if (commit) begin
         if (kind_ff == KindTimes) begin
            for (int i = 0; i < 3; i++) begin
               if (pend_valid_in[i]) begin
                  com_times_in[i] = pend_times_in[i];
                  com_valid_in[i] = 1'b1;
               end
            end
         end else if (kind_ff == KindUnix && len_ff >= 16'd3 &&
                      18'd3 + {10'h000, uid_len_in} + {10'h000, gid_len_in}
                      <= {2'b00, len_ff}) begin
            com_ids_in[0]          = pend_ids_in[0];
            com_ids_in[1]          = pend_ids_in[1];
            com_valid_in[ValidIds] = 1'b1;
         end
      end

      result.has_mtime    = com_valid_in[ValidMtime];
      result.mtime        = com_valid_in[ValidMtime] ? com_times_in[0] : 32'h0;
      result.has_atime    = com_valid_in[ValidAtime];
      result.atime        = com_valid_in[ValidAtime] ? com_times_in[1] : 32'h0;
      result.has_ctime    = com_valid_in[ValidCtime];
      result.ctime        = com_valid_in[ValidCtime] ? com_times_in[2] : 32'h0;
      result.has_unix_ids = com_valid_in[ValidIds];
      result.user_id      = com_valid_in[ValidIds] ? com_ids_in[0] : 32'h0;
      result.group_id     = com_valid_in[ValidIds] ? com_ids_in[1] : 32'h0;

      // The marked byte ends the field; the next field starts from scratch.
      if (step && last_byte) begin
         phase_in      = PHASE_HEADER;
         hdr_cnt_in    = '0;
         kind_in       = '0;
         len_in        = '0;
         off_in        = '0;
         flags_in      = '0;
         uid_len_in    = '0;
         gid_len_in    = '0;
         asm_in        = '0;
         pend_times_in = '{default: '0};
         pend_ids_in   = '{default: '0};
         pend_valid_in = '0;
         com_times_in  = '{default: '0};
         com_ids_in    = '{default: '0};
         com_valid_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         hdr_cnt_ff    <= '0;
         kind_ff       <= '0;
         len_ff        <= '0;
         off_ff        <= '0;
         flags_ff      <= '0;
         uid_len_ff    <= '0;
         gid_len_ff    <= '0;
         asm_ff        <= '0;
         pend_times_ff <= '{default: '0};
         pend_ids_ff   <= '{default: '0};
         pend_valid_ff <= '0;
         com_times_ff  <= '{default: '0};
         com_ids_ff    <= '{default: '0};
         com_valid_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         kind_ff       <= kind_in;
         len_ff        <= len_in;
         off_ff        <= off_in;
         flags_ff      <= flags_in;
         uid_len_ff    <= uid_len_in;
         gid_len_ff    <= gid_len_in;
         asm_ff        <= asm_in;
         pend_times_ff <= pend_times_in;
         pend_ids_ff   <= pend_ids_in;
         pend_valid_ff <= pend_valid_in;
         com_times_ff  <= com_times_in;
         com_ids_ff    <= com_ids_in;
         com_valid_ff  <= com_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/zip_extra_field_parser_top.sv
// ZIP extra-field parser, top level. The block takes the extra field of one central
// directory entry as a stream of bytes, one byte per word, and sustains one byte per
// clock cycle. It walks the records of the field (little-endian 16-bit id and size),
// picks up the extended timestamp record (mtime, atime, ctime, each only if nonzero)
// and the Unix owner record (uid and gid, low 32 bits), and gives one result word when
// the byte marked as last arrives. A record only takes effect once its final payload
// byte is in; a record cut short by the end of the field, or a tail shorter than a
// header, is dropped, and later records overwrite earlier ones. Each byte passes an
// input register and then one pass of the record walker; when the last byte passes, the
// result word goes into the result register and waits there until the sink takes it.
// The input side keeps taking bytes while a result waits; only a second last byte held
// up behind an untaken result stalls it.
// Depends on zefp_pkg, zefp_req_if, zefp_rsp_if, zefp_parser and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module zip_extra_field_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   zefp_req_if.sink   req_if,
   zefp_rsp_if.source rsp_if
);
   import zefp_pkg::*;

   // Input register: holds one byte until the walker takes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_last_ff,  in_last_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       advance;
   logic       req_take;
   result_type walk_result;

   // The held byte moves on unless it is a last byte and the result register is
   // still occupied by a word the sink has not taken.
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   zefp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (walk_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_last_in  = req_if.last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = walk_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.has_mtime    = rsp_ff.has_mtime;
   assign rsp_if.mtime        = rsp_ff.mtime;
   assign rsp_if.has_atime    = rsp_ff.has_atime;
   assign rsp_if.atime        = rsp_ff.atime;
   assign rsp_if.has_ctime    = rsp_ff.has_ctime;
   assign rsp_if.ctime        = rsp_ff.ctime;
   assign rsp_if.has_unix_ids = rsp_ff.has_unix_ids;
   assign rsp_if.user_id      = rsp_ff.user_id;
   assign rsp_if.group_id     = rsp_ff.group_id;

   // Terms the checks below are written in.
   logic       times_match;
   logic       ids_ok;
   logic       in_stall;
   logic [8:0] in_word;
   logic       rsp_idle;

   assign times_match = (rsp_ff.has_mtime == (rsp_ff.mtime != 32'h0)) &&
                        (rsp_ff.has_atime == (rsp_ff.atime != 32'h0)) &&
                        (rsp_ff.has_ctime == (rsp_ff.ctime != 32'h0));
   assign ids_ok      = rsp_ff.has_unix_ids ||
                        (rsp_ff.user_id == 32'h0 && rsp_ff.group_id == 32'h0);
   assign in_stall    = in_valid_ff && !advance;
   assign in_word     = {in_byte_ff, in_last_ff};
   assign rsp_idle    = !rsp_valid_ff && !(advance && in_last_ff);

   // A time flag is set exactly when its time is nonzero.
   `ASSERT_SAME(a_time_flags, rsp_valid_ff, times_match, "time flag disagrees with time value")
   // Without a complete owner record both ids read as zero.
   `ASSERT_SAME(a_ids_zero, rsp_valid_ff, ids_ok, "owner ids nonzero without an owner record")
   // A held byte that cannot move on keeps its value.
   `ASSERT_NEXT(a_in_hold, in_stall, in_valid_ff && $stable(in_word), "held byte lost")
   // Only a last byte fills the empty result register.
   `ASSERT_NEXT(a_rsp_on_last, rsp_idle, !rsp_valid_ff, "result word without a last byte")

endmodule

`default_nettype wire
